FILE: hdl/vdu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdu_pkg
// Shared types, constants and codes for the vector distance unit.
// ----------------------------------------------------------------------------
package vdu_pkg;

    // Element count above which the sums are reported as saturated.
    localparam int MAX_DIM = 4096;
    localparam int CNT_W   = $clog2(MAX_DIM + 2);
    localparam int SUM_W   = 48;
    localparam int ROOT_W  = SUM_W / 2;
    localparam int NUM_W   = SUM_W + 15;

    localparam logic [1:0] MODE_EUCLID = 2'd0;
    localparam logic [1:0] MODE_INNER  = 2'd1;
    localparam logic [1:0] MODE_COSINE = 2'd2;

    localparam logic [1:0] SQ_SRC_DIFF   = 2'd0;
    localparam logic [1:0] SQ_SRC_FIRST  = 2'd1;
    localparam logic [1:0] SQ_SRC_SECOND = 2'd2;

    typedef struct packed {
        logic signed [15:0] a_value;
        logic signed [15:0] b_value;
        logic               last_element;
    } in_item_t;

    typedef struct packed {
        logic signed [47:0] score;
        logic               zero_norm;
        logic               saturated;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL,
        ST_ACC,
        ST_FIN,
        ST_SQA,
        ST_SQB,
        ST_PROD,
        ST_DIVL,
        ST_DIV,
        ST_OUT
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;
        logic       mul;
        logic       acc;
        logic       sq_load;
        logic [1:0] sq_src;
        logic       sq_step;
        logic       save_na;
        logic       prod;
        logic       div_load;
        logic       div_step;
        logic       res_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic       last;
        logic [1:0] mode;
        logic       zero;
        logic       sq_done;
        logic       div_done;
    } status_t;

endpackage : vdu_pkg
`default_nettype wire

FILE: hdl/vdu_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdu_ctrl
// Sequencer that steps one request through multiply and accumulate and, on the last element, root, divide, output.
// ----------------------------------------------------------------------------
module vdu_ctrl
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  wire logic            out_stall,
    input  wire vdu_pkg::status_t sts,
    output vdu_pkg::cmd_t        cmd
);
    import vdu_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                cmd.acc    = 1'b1;
                state_next = sts.last ? ST_FIN : ST_IDLE;
            end
            ST_FIN:
            begin
                if (sts.mode == MODE_INNER ||
                    (sts.mode == MODE_COSINE && sts.zero))
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_OUT;
                end
                else
                begin
                    cmd.sq_load = 1'b1;
                    cmd.sq_src  = (sts.mode == MODE_COSINE) ? SQ_SRC_FIRST : SQ_SRC_DIFF;
                    state_next  = ST_SQA;
                end
            end
            ST_SQA:
            begin
                if (!sts.sq_done)
                begin
                    cmd.sq_step = 1'b1;
                end
                else if (sts.mode == MODE_COSINE)
                begin
                    cmd.save_na = 1'b1;
                    cmd.sq_load = 1'b1;
                    cmd.sq_src  = SQ_SRC_SECOND;
                    state_next  = ST_SQB;
                end
                else
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_OUT;
                end
            end
            ST_SQB:
            begin
                if (!sts.sq_done)
                begin
                    cmd.sq_step = 1'b1;
                end
                else
                begin
                    state_next = ST_PROD;
                end
            end
            ST_PROD:
            begin
                cmd.prod   = 1'b1;
                state_next = ST_DIVL;
            end
            ST_DIVL:
            begin
                cmd.div_load = 1'b1;
                state_next   = ST_DIV;
            end
            ST_DIV:
            begin
                if (!sts.div_done)
                begin
                    cmd.div_step = 1'b1;
                end
                else
                begin
                    cmd.res_load = 1'b1;
                    state_next   = ST_OUT;
                end
            end
            ST_OUT:
            begin
                out_valid = 1'b1;
                if (!out_stall)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // A result is never shown while a new request can be taken.
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> in_stall)
        else $error("result and new request overlap");

    // A taken request always moves on to the multiply step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> (state_reg == ST_MUL))
        else $error("accepted request not started");

    // A stalled result stays on offer.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("stalled result withdrawn");

endmodule : vdu_ctrl
`default_nettype wire

FILE: hdl/vdu_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vdu_dp
// Products, saturating sums, iterative square root, divider and result register.
// ----------------------------------------------------------------------------
module vdu_dp
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire vdu_pkg::in_item_t in_data,
    input  wire logic              cfg_we,
    input  wire logic [1:0]        cfg_data,
    input  wire vdu_pkg::cmd_t     cmd,
    output vdu_pkg::status_t       sts,
    output vdu_pkg::out_item_t     out_data
);
    import vdu_pkg::*;

    localparam logic signed [SUM_W:0] SAT_HI = {2'b00, {(SUM_W - 1){1'b1}}};
    localparam logic signed [SUM_W:0] SAT_LO = {2'b11, {(SUM_W - 1){1'b0}}};

    logic [1:0]               mode_reg;
    in_item_t                 item_reg;
    logic signed [33:0]       pd_reg;
    logic signed [33:0]       pp_reg;
    logic signed [33:0]       pa_reg;
    logic signed [33:0]       pb_reg;
    logic signed [SUM_W-1:0]  diff_reg;
    logic signed [SUM_W-1:0]  dot_reg;
    logic signed [SUM_W-1:0]  fsq_reg;
    logic signed [SUM_W-1:0]  ssq_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic [SUM_W-1:0]         sqx_reg;
    logic [ROOT_W+1:0]        sqr_reg;
    logic [ROOT_W-1:0]        root_reg;
    logic [$clog2(ROOT_W+1)-1:0] sqc_reg;
    logic [ROOT_W-1:0]        na_reg;
    logic [SUM_W-1:0]         den_reg;
    logic [SUM_W-1:0]         drem_reg;
    logic [NUM_W-1:0]         dq_reg;
    logic [$clog2(NUM_W+1)-1:0] dc_reg;
    out_item_t                out_reg;

    logic signed [16:0]       a_ext;
    logic signed [16:0]       b_ext;
    logic signed [16:0]       d_ext;
    logic [ROOT_W+1:0]        sq_shift;
    logic [ROOT_W+1:0]        sq_trial;
    logic [SUM_W:0]           dv_trial;
    logic [SUM_W-1:0]         dot_mag;
    logic signed [SUM_W:0]    inner_sum;
    logic [15:0]              cos_mag;
    logic signed [SUM_W-1:0]  cos_score;
    logic signed [SUM_W-1:0]  score_sel;
    logic                     zero_w;

    // Saturating accumulate of one product into a 48-bit sum.
    function automatic logic signed [SUM_W-1:0] sat_add(
        input logic signed [SUM_W-1:0] acc,
        input logic signed [33:0]      term
    );
        logic signed [SUM_W:0] s;
        s = {acc[SUM_W-1], acc} + {{(SUM_W - 33){term[33]}}, term};
        if (s > SAT_HI)
        begin
            return SAT_HI[SUM_W-1:0];
        end
        else if (s < SAT_LO)
        begin
            return SAT_LO[SUM_W-1:0];
        end
        return s[SUM_W-1:0];
    endfunction

    // Metric register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_EUCLID;
        end
        else if (cfg_we)
        begin
            mode_reg <= cfg_data;
        end
    end

    assign a_ext = {item_reg.a_value[15], item_reg.a_value};
    assign b_ext = {item_reg.b_value[15], item_reg.b_value};
    assign d_ext = a_ext - b_ext;

    // Input capture and products.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_data;
        end
        if (cmd.mul)
        begin
            pd_reg <= 34'(d_ext * d_ext);
            pp_reg <= 34'(a_ext * b_ext);
            pa_reg <= 34'(a_ext * a_ext);
            pb_reg <= 34'(b_ext * b_ext);
        end
    end

    // Running sums and element count; cleared when a result is loaded into the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_reg <= '0;
            dot_reg  <= '0;
            fsq_reg  <= '0;
            ssq_reg  <= '0;
            cnt_reg  <= '0;
        end
        else if (cmd.res_load)
        begin
            diff_reg <= '0;
            dot_reg  <= '0;
            fsq_reg  <= '0;
            ssq_reg  <= '0;
            cnt_reg  <= '0;
        end
        else if (cmd.acc)
        begin
            diff_reg <= sat_add(diff_reg, pd_reg);
            dot_reg  <= sat_add(dot_reg, pp_reg);
            fsq_reg  <= sat_add(fsq_reg, pa_reg);
            ssq_reg  <= sat_add(ssq_reg, pb_reg);
            if (cnt_reg <= CNT_W'(MAX_DIM))
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
        end
    end

    // Square root, two radicand bits a step.
    assign sq_shift = {sqr_reg[ROOT_W-1:0], sqx_reg[SUM_W-1:SUM_W-2]};
    assign sq_trial = {root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sqc_reg <= '0;
        end
        else if (cmd.sq_load)
        begin
            sqc_reg <= ($clog2(ROOT_W + 1))'(ROOT_W);
        end
        else if (cmd.sq_step)
        begin
            sqc_reg <= sqc_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sq_load)
        begin
            case (cmd.sq_src)
                SQ_SRC_FIRST:  sqx_reg <= fsq_reg;
                SQ_SRC_SECOND: sqx_reg <= ssq_reg;
                default:       sqx_reg <= diff_reg;
            endcase
            sqr_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.sq_step)
        begin
            sqx_reg <= {sqx_reg[SUM_W-3:0], 2'b00};
            if (sq_shift >= sq_trial)
            begin
                sqr_reg  <= sq_shift - sq_trial;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                sqr_reg  <= sq_shift;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
        if (cmd.save_na)
        begin
            na_reg <= root_reg;
        end
        if (cmd.prod)
        begin
            den_reg <= na_reg * root_reg;
        end
    end

    // Restoring divide of the scaled dot product magnitude, one bit a step.
    assign dot_mag  = dot_reg[SUM_W-1] ? SUM_W'(-dot_reg) : dot_reg;
    assign dv_trial = {drem_reg, dq_reg[NUM_W-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dc_reg <= '0;
        end
        else if (cmd.div_load)
        begin
            dc_reg <= ($clog2(NUM_W + 1))'(NUM_W);
        end
        else if (cmd.div_step)
        begin
            dc_reg <= dc_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            drem_reg <= '0;
            dq_reg   <= {dot_mag, 15'd0};
        end
        else if (cmd.div_step)
        begin
            if (dv_trial >= {1'b0, den_reg})
            begin
                drem_reg <= SUM_W'(dv_trial - {1'b0, den_reg});
                dq_reg   <= {dq_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                drem_reg <= dv_trial[SUM_W-1:0];
                dq_reg   <= {dq_reg[NUM_W-2:0], 1'b0};
            end
        end
    end

    // Result selection.
    assign zero_w    = (fsq_reg == '0) || (ssq_reg == '0);
    assign inner_sum = {dot_reg[SUM_W-1], dot_reg} + (SUM_W + 1)'(16384);
    assign cos_mag   = (dq_reg > NUM_W'(32768)) ? 16'd32768 : dq_reg[15:0];
    assign cos_score = dot_reg[SUM_W-1] ? -SUM_W'(cos_mag) : SUM_W'(cos_mag);

    always_comb
    begin
        case (mode_reg)
            MODE_INNER:  score_sel = SUM_W'(inner_sum >>> 15);
            MODE_COSINE: score_sel = zero_w ? '0 : cos_score;
            default:     score_sel = SUM_W'(root_reg);
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            out_reg.score     <= score_sel;
            out_reg.zero_norm <= (mode_reg == MODE_COSINE) && zero_w;
            out_reg.saturated <= cnt_reg > CNT_W'(MAX_DIM);
        end
    end

    assign out_data     = out_reg;
    assign sts.last     = item_reg.last_element;
    assign sts.mode     = mode_reg;
    assign sts.zero     = zero_w;
    assign sts.sq_done  = (sqc_reg == '0);
    assign sts.div_done = (dc_reg == '0);

endmodule : vdu_dp
`default_nettype wire

FILE: hdl/vector_distance_unit_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Each element without the last mark goes through the multiply and accumulate states,
// during which no new request is taken. On the last element, Euclidean adds a 24-step
// root, cosine adds two 24-step roots, one multiply and a 63-step divider, and inner
// product or a zero-norm cosine goes straight to output; then the result waits for take-up.
// Reset clears the sums, the count, the sequencer and sets the metric to Euclidean.
// ----------------------------------------------------------------------------
// vector_distance_unit_top
// Streaming Euclidean, inner product and cosine scorer for Q1.15 vector pairs.
// ----------------------------------------------------------------------------
module vector_distance_unit_top
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire vdu_pkg::in_item_t  in_data,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output vdu_pkg::out_item_t      out_data,
    input  wire logic               cfg_we,
    input  wire logic [1:0]         cfg_data
);
    import vdu_pkg::*;

    cmd_t    cmd;
    status_t sts;

    // Sequencer.
    vdu_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    // Arithmetic.
    vdu_dp u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .cmd      (cmd),
        .sts      (sts),
        .out_data (out_data)
    );

endmodule : vector_distance_unit_top
`default_nettype wire

FILE: tb/sv/tb_vector_distance_unit_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_vector_distance_unit_top
// Self-checking bench for the vector distance unit: element pairs are streamed
// with random gaps, each metric is exercised, and every score is compared with
// a scoreboard prediction worked out from the accumulated sums.
// ----------------------------------------------------------------------------
module tb_vector_distance_unit_top;
    import vdu_pkg::*;

    localparam logic signed [47:0] SUM_HI = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] SUM_LO = 48'sh8000_0000_0000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_item_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_item_t out_data;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_data = MODE_EUCLID;

    // Predictor state.
    logic [1:0] metric_sel;
    logic signed [47:0] diff_acc, dot_acc, a_sq_acc, b_sq_acc;
    int unsigned elem_cnt;
    out_item_t score_queue[$];
    int unsigned fail_count = 0;
    int unsigned score_count = 0;
    int unsigned request_count = 0;
    int idle_pct = 28;

    vector_distance_unit_top dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_data(cfg_data)
    );

    always #10 clk = ~clk;

    // Saturating 48-bit accumulate.
    function automatic logic signed [47:0] sat_accum(logic signed [47:0] acc,
                                                     longint term);
        longint s;
        s = longint'(acc) + term;
        if (s > longint'(SUM_HI))
            return SUM_HI;
        if (s < longint'(SUM_LO))
            return SUM_LO;
        return s[47:0];
    endfunction

    // Integer square root, bit by bit.
    function automatic longint int_root(longint x);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 <<< 62;
        while (b > x)
            b = b >>> 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x = x - (r + b);
                r = (r >>> 1) + b;
            end
            else
                r = r >>> 1;
            b = b >>> 2;
        end
        return r;
    endfunction

    // Accumulates one element and, on the last mark, queues the expected score.
    task automatic predict_score(in_item_t it);
        longint a, b, d, sc, x, den;
        out_item_t r;
        a = it.a_value;
        b = it.b_value;
        d = a - b;
        diff_acc = sat_accum(diff_acc, d * d);
        dot_acc  = sat_accum(dot_acc, a * b);
        a_sq_acc = sat_accum(a_sq_acc, a * a);
        b_sq_acc = sat_accum(b_sq_acc, b * b);
        if (elem_cnt <= MAX_DIM)
            elem_cnt++;
        if (!it.last_element)
            return;
        r = '0;
        r.saturated = (elem_cnt > MAX_DIM);
        sc = 0;
        if (metric_sel == MODE_INNER)
        begin
            x = longint'(dot_acc) + 16384;
            if (x >= 0)
                sc = x / 32768;
            else
                sc = -((-x + 32767) / 32768);
        end
        else if (metric_sel == MODE_COSINE)
        begin
            if (a_sq_acc <= 0 || b_sq_acc <= 0)
                r.zero_norm = 1'b1;
            else
            begin
                den = int_root(a_sq_acc) * int_root(b_sq_acc);
                sc = (longint'(dot_acc) * 32768) / den;
                if (sc > 32768)
                    sc = 32768;
                if (sc < -32768)
                    sc = -32768;
            end
        end
        else
            sc = int_root(diff_acc > 0 ? longint'(diff_acc) : 0);
        r.score = sc[47:0];
        score_queue.push_back(r);
        diff_acc = '0;
        dot_acc = '0;
        a_sq_acc = '0;
        b_sq_acc = '0;
        elem_cnt = 0;
    endtask

    // Sends one request, with a random gap ahead of it. Valid stays high after
    // the accepting edge so that a back-to-back request needs no second update.
    task automatic send_element(logic signed [15:0] a, logic signed [15:0] b, logic last);
        in_item_t it;
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        it.a_value = a;
        it.b_value = b;
        it.last_element = last;
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_score(it);
        request_count++;
    endtask

    // Drops valid, waits for the queue to drain, then lets the sequencer settle.
    task automatic drain_scores();
        in_valid <= 1'b0;
        while (score_queue.size() != 0)
            @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic write_metric(logic [1:0] m);
        drain_scores();
        cfg_we <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        cfg_we <= 1'b0;
        metric_sel = m;
    endtask

    task automatic send_vector(int len, int kind);
        logic signed [15:0] a, b;
        for (int i = 0; i < len; i++)
        begin
            a = 16'($urandom);
            b = 16'($urandom);
            case (kind)
                1: b = a;
                2: b = -a;
                3: a = 16'sh0000;
                4: begin a = 16'($urandom_range(255)); b = 16'($urandom_range(255)); end
                default: ;
            endcase
            send_element(a, b, i == len - 1);
        end
    endtask

    // Checks each score against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (score_queue.size() == 0)
            begin
                $error("unexpected score %0d", out_data.score);
                fail_count++;
            end
            else
            begin
                out_item_t e;
                e = score_queue.pop_front();
                score_count++;
                if (out_data.score !== e.score)
                begin
                    $error("score: expected %0d, actual %0d", e.score, out_data.score);
                    fail_count++;
                end
                if (out_data.zero_norm !== e.zero_norm)
                begin
                    $error("zero_norm: expected %0b, actual %0b",
                           e.zero_norm, out_data.zero_norm);
                    fail_count++;
                end
                if (out_data.saturated !== e.saturated)
                begin
                    $error("saturated: expected %0b, actual %0b",
                           e.saturated, out_data.saturated);
                    fail_count++;
                end
            end
        end
    end

    // Random stall on the result side.
    always @(posedge clk)
        out_stall <= ($urandom_range(99) < idle_pct);

    // Extremes of the element range under every metric.
    task automatic test_extremes();
        for (int m = 0; m < 4; m++)
        begin
            write_metric(m[1:0]);
            send_element(16'sh7FFF, 16'sh8000, 1'b1);
            send_element(16'sh8000, 16'sh8000, 1'b0);
            send_element(16'sh7FFF, 16'sh7FFF, 1'b1);
            send_element(16'sh0000, 16'sh0000, 1'b1);
            send_element(16'sh0000, 16'sh7FFF, 1'b1);
            send_element(16'sh8000, 16'sh7FFF, 1'b1);
        end
    endtask

    // Random vectors of mostly short length under changing metrics.
    task automatic test_random();
        int len;
        for (int p = 0; p < 12; p++)
        begin
            write_metric(2'($urandom_range(3)));
            idle_pct = (p == 5) ? 0 : 28;
            for (int v = 0; v < 26; v++)
            begin
                len = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(6, 1);
                send_vector(len, $urandom_range(5));
            end
        end
        idle_pct = 28;
    endtask

    initial
    begin
        metric_sel = MODE_EUCLID;
        diff_acc = '0;
        dot_acc = '0;
        a_sq_acc = '0;
        b_sq_acc = '0;
        elem_cnt = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        test_random();
        write_metric(MODE_COSINE);
        drain_scores();
        $display("Covered %0d requests and %0d scores over all metrics,", request_count,
                 score_count);
        $display("including extreme elements, zero norms and clamped cosines.");
        if (fail_count == 0 && score_queue.size() == 0)
            $display("PASS vector_distance_unit_top");
        else
            $display("FAIL vector_distance_unit_top");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("FAIL vector_distance_unit_top");
        $finish;
    end
endmodule
